// ===== rtl/core/keyed_max_priority_queue_defines.svh =====
// Assertion macros for the keyed max priority queue checkers.
`ifndef KEYED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define KEYED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kmpq_pkg.sv =====
// Types, codes and constants shared by the keyed max priority queue.
package kmpq_pkg;

    localparam int DEPTH      = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int RESULT_CAP = 32;
    localparam int EMIT_W     = $clog2(RESULT_CAP);
    localparam int CNT_W      = 6;
    localparam int ADDR_W     = 3;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP_TOP = 2'd1;
    localparam logic [1:0] OP_POP_KEY = 2'd2;
    localparam logic [1:0] OP_SWEEP   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_RAISED    = 3'd1;
    localparam logic [2:0] ST_DISCARDED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_EXPIRED   = 3'd6;

    localparam logic REG_EXPIRE_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  entry_key;
        logic [15:0] priority_req;
        logic [15:0] event_tag;
        logic [31:0] now_seconds;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_key;
        logic [15:0] result_priority;
        logic [15:0] result_tag;
        logic [5:0]  entry_count;
        logic        top_valid;
        logic [7:0]  top_key;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] prio;
        logic [15:0] tag;
        logic [31:0] birth;
        logic [31:0] order;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ACT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic scan_clr;
        logic scan_rd;
        logic act;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
        logic last;
    } t_sts;

endpackage

// ===== rtl/core/kmpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kmpq_dp.sv =====
// Datapath: slot store, scan compare, update decision and result register.
module kmpq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmpq_pkg::t_in_word  i_in_word,
    input  logic [15:0]         i_limit,
    input  kmpq_pkg::t_cmd      i_cmd,
    output kmpq_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kmpq_pkg::t_out_word o_out_word
);

    localparam int IW = kmpq_pkg::IDX_W;

    kmpq_pkg::t_in_word  r_in;
    logic [kmpq_pkg::DEPTH-1:0] r_valid;
    logic [kmpq_pkg::CNT_W-1:0] r_count;
    logic [31:0]         r_order;
    logic [IW-1:0]       r_idx;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;

    logic                r_hit;
    logic [IW-1:0]       r_hit_idx;
    kmpq_pkg::t_slot     r_hit_slot;
    logic                r_free_vld;
    logic [IW-1:0]       r_free_idx;
    logic                r_top_vld;
    logic [IW-1:0]       r_top_idx;
    kmpq_pkg::t_slot     r_top_slot;
    logic                r_exp_vld;
    logic [IW-1:0]       r_exp_idx;
    kmpq_pkg::t_slot     r_exp_slot;

    logic [2:0]          r_res_status;
    logic [7:0]          r_res_key;
    logic [15:0]         r_res_pri;
    logic [15:0]         r_res_tag;
    logic [kmpq_pkg::EMIT_W-1:0] r_emit_n;

    logic                r_out_valid;
    kmpq_pkg::t_out_word r_out_word;

    logic [kmpq_pkg::SLOT_W-1:0] ram_rdata;
    kmpq_pkg::t_slot     q;
    logic                q_v;
    logic [31:0]         age;
    logic                take_hit, take_free, take_top, take_exp;

    logic                n_we;
    logic [IW-1:0]       n_waddr;
    kmpq_pkg::t_slot     n_wslot;
    logic                n_set_v, n_clr_v;
    logic [IW-1:0]       n_vaddr;
    logic                n_inc, n_dec;
    logic [2:0]          n_status;
    logic [7:0]          n_key;
    logic [15:0]         n_pri, n_tag;

    kmpq_ram #(
        .WIDTH (kmpq_pkg::SLOT_W),
        .DEPTH (kmpq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wslot),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Scan compare on the word read back in the cycle after its address.
    always_comb begin
        q    = kmpq_pkg::t_slot'(ram_rdata);
        q_v  = r_rd_vld && r_valid[r_rd_idx];
        age  = r_in.now_seconds - q.birth;
        take_hit  = q_v && !r_hit && (q.key == r_in.entry_key);
        take_free = r_rd_vld && !r_valid[r_rd_idx] && !r_free_vld;
        take_top  = q_v && (!r_top_vld || (q.prio > r_top_slot.prio) ||
                    ((q.prio == r_top_slot.prio) && (q.order > r_top_slot.order)));
        take_exp  = q_v && (i_limit != 16'd0) && (age >= {16'd0, i_limit}) &&
                    (!r_exp_vld || (q.prio < r_exp_slot.prio) ||
                    ((q.prio == r_exp_slot.prio) && (q.order < r_exp_slot.order)));
    end

    // Update decision from the most recent scan of an item.
    always_comb begin
        n_we     = 1'b0;
        n_waddr  = r_hit_idx;
        n_wslot  = r_hit_slot;
        n_set_v  = 1'b0;
        n_clr_v  = 1'b0;
        n_vaddr  = r_hit_idx;
        n_inc    = 1'b0;
        n_dec    = 1'b0;
        n_status = kmpq_pkg::ST_NOT_FOUND;
        n_key    = 8'd0;
        n_pri    = 16'd0;
        n_tag    = 16'd0;
        case (r_in.operation)
            kmpq_pkg::OP_PUSH: begin
                n_key = r_in.entry_key;
                if (r_hit) begin
                    if (r_in.priority_req > r_hit_slot.prio) begin
                        n_status      = kmpq_pkg::ST_RAISED;
                        n_we          = i_cmd.act;
                        n_wslot.prio  = r_in.priority_req;
                        n_wslot.tag   = r_in.event_tag;
                        n_wslot.order = r_order;
                        n_inc         = 1'b1;
                    end else begin
                        n_status = kmpq_pkg::ST_DISCARDED;
                    end
                end else if ((32'(r_count) >= kmpq_pkg::DEPTH) || !r_free_vld) begin
                    n_status = kmpq_pkg::ST_FULL;
                end else begin
                    n_status = kmpq_pkg::ST_INSERTED;
                    n_we     = i_cmd.act;
                    n_waddr  = r_free_idx;
                    n_wslot  = '{key: r_in.entry_key, prio: r_in.priority_req,
                                 tag: r_in.event_tag, birth: r_in.now_seconds,
                                 order: r_order};
                    n_set_v  = 1'b1;
                    n_vaddr  = r_free_idx;
                    n_inc    = 1'b1;
                end
            end
            kmpq_pkg::OP_POP_TOP: begin
                if (r_top_vld) begin
                    n_status = kmpq_pkg::ST_REMOVED;
                    n_key    = r_top_slot.key;
                    n_pri    = r_top_slot.prio;
                    n_tag    = r_top_slot.tag;
                    n_clr_v  = 1'b1;
                    n_vaddr  = r_top_idx;
                    n_dec    = 1'b1;
                end
            end
            kmpq_pkg::OP_POP_KEY: begin
                n_key = r_in.entry_key;
                if (r_hit) begin
                    n_status = kmpq_pkg::ST_REMOVED;
                    n_pri    = r_hit_slot.prio;
                    n_tag    = r_hit_slot.tag;
                    n_clr_v  = 1'b1;
                    n_vaddr  = r_hit_idx;
                    n_dec    = 1'b1;
                end
            end
            kmpq_pkg::OP_SWEEP: begin
                if (r_exp_vld) begin
                    n_status = kmpq_pkg::ST_EXPIRED;
                    n_key    = r_exp_slot.key;
                    n_pri    = r_exp_slot.prio;
                    n_tag    = r_exp_slot.tag;
                    n_clr_v  = 1'b1;
                    n_vaddr  = r_exp_idx;
                    n_dec    = 1'b1;
                end
            end
            default: begin
                n_status = kmpq_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_order     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_free_vld  <= 1'b0;
            r_top_vld   <= 1'b0;
            r_exp_vld   <= 1'b0;
            r_emit_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_rd) begin
                r_idx    <= r_idx + 1'b1;
                r_rd_idx <= r_idx;
            end
            if (i_cmd.scan_clr) begin
                r_idx      <= '0;
                r_hit      <= 1'b0;
                r_free_vld <= 1'b0;
                r_top_vld  <= 1'b0;
                r_exp_vld  <= 1'b0;
            end else begin
                if (take_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rd_idx;
                    r_hit_slot <= q;
                end
                if (take_free) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (take_top) begin
                    r_top_vld  <= 1'b1;
                    r_top_idx  <= r_rd_idx;
                    r_top_slot <= q;
                end
                if (take_exp) begin
                    r_exp_vld  <= 1'b1;
                    r_exp_idx  <= r_rd_idx;
                    r_exp_slot <= q;
                end
            end
            if (i_cmd.latch_in) begin
                r_in     <= i_in_word;
                r_emit_n <= '0;
            end
            if (i_cmd.act) begin
                r_res_status <= n_status;
                r_res_key    <= n_key;
                r_res_pri    <= n_pri;
                r_res_tag    <= n_tag;
                if (n_set_v) begin
                    r_valid[n_vaddr] <= 1'b1;
                end
                if (n_clr_v) begin
                    r_valid[n_vaddr] <= 1'b0;
                end
                if (n_inc && (n_status == kmpq_pkg::ST_INSERTED)) begin
                    r_count <= r_count + 1'b1;
                end
                if (n_dec) begin
                    r_count <= r_count - 1'b1;
                end
                if (n_inc) begin
                    r_order <= r_order + 32'd1;
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
                r_emit_n    <= r_emit_n + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_word <= '{status: r_res_status, result_key: r_res_key,
                            result_priority: r_res_pri, result_tag: r_res_tag,
                            entry_count: r_count, top_valid: r_top_vld,
                            top_key: r_top_vld ? r_top_slot.key : 8'd0,
                            last: o_sts.last};
        end
    end

    // A sweep keeps going while the rescan still finds an expired entry, up to RESULT_CAP result words.
    always_comb begin
        o_sts.scan_end = i_cmd.scan_rd && (r_idx == IW'(kmpq_pkg::DEPTH - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.last     = (r_in.operation != kmpq_pkg::OP_SWEEP) ||
                         (r_res_status != kmpq_pkg::ST_EXPIRED) || !r_exp_vld ||
                         (r_emit_n == kmpq_pkg::EMIT_W'(kmpq_pkg::RESULT_CAP - 1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/kmpq_ctrl.sv =====
// Controller: sequences scan, update, rescan and result hand-off.
module kmpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kmpq_pkg::t_sts i_sts,
    output kmpq_pkg::t_cmd o_cmd
);

    kmpq_pkg::t_state r_state, n_state;
    logic             r_acted;

    always_comb begin
        n_state = r_state;
        case (r_state)
            kmpq_pkg::S_IDLE:  if (i_in_valid) n_state = kmpq_pkg::S_SCAN;
            kmpq_pkg::S_SCAN:  if (i_sts.scan_end) n_state = kmpq_pkg::S_DRAIN;
            kmpq_pkg::S_DRAIN: n_state = r_acted ? kmpq_pkg::S_EMIT : kmpq_pkg::S_ACT;
            kmpq_pkg::S_ACT:   n_state = kmpq_pkg::S_SCAN;
            kmpq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last ? kmpq_pkg::S_IDLE : kmpq_pkg::S_ACT;
                end
            end
            default: n_state = kmpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            kmpq_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                o_cmd.scan_clr = i_in_valid;
            end
            kmpq_pkg::S_SCAN: o_cmd.scan_rd = 1'b1;
            kmpq_pkg::S_ACT: begin
                o_cmd.act      = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            kmpq_pkg::S_EMIT: o_cmd.emit_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmpq_pkg::S_IDLE;
            r_acted <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.latch_in) begin
                r_acted <= 1'b0;
            end else if (o_cmd.act) begin
                r_acted <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/keyed_max_priority_queue.sv =====
// Top level of the keyed max priority queue: config register and core.
//
// Input channel i_in_valid / o_in_ready carries one command word: push,
// pop highest, pop by key or expiry sweep. Output channel o_out_valid /
// i_out_ready returns result words; last marks the final word of a command.
// The APB port holds expire_limit_seconds at byte address 0; pready is tied
// high and writes take effect on the access cycle.
//
// Each command is handled by one pass over the slot RAM (one slot per
// cycle), an update step, a second pass that finds the new top entry,
// and a hand-off. Each further word of a sweep takes another update step
// and pass. The single RAM read port is the pace-setter. A new command is
// accepted only when the previous one has handed off its last word; the
// output register keeps that word until it is taken.
//
// Reset clears the slot valid bits, counters and the limit.
// When the receiver stalls, the result word holds and the sequencer waits
// in its hand-off state; nothing is lost or repeated.
module keyed_max_priority_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  kmpq_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output kmpq_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [15:0]    r_limit;
    kmpq_pkg::t_cmd cmd;
    kmpq_pkg::t_sts sts;

    // Register index is the word address bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd0;
        end else begin
            if (psel && penable && pwrite && (paddr[2] == kmpq_pkg::REG_EXPIRE_LIMIT)) begin
                r_limit <= pwdata[15:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kmpq_pkg::REG_EXPIRE_LIMIT) ? {16'd0, r_limit} : 32'd0;

    kmpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kmpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_limit     (r_limit),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/core/kmpq_chk.sv =====
// Port-level checker for the keyed max priority queue, with its bind.
`include "keyed_max_priority_queue_defines.svh"

module kmpq_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input kmpq_pkg::t_in_word          i_in_word,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input kmpq_pkg::t_out_word         o_out_word,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [kmpq_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);

    `KMPQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "result word changed while stalled")
    `KMPQ_ASSERT_NOW(a_count_max, o_out_valid, 32'(o_out_word.entry_count) <= kmpq_pkg::DEPTH, "entry count above depth")
    `KMPQ_ASSERT_NOW(a_top_count, o_out_valid, o_out_word.top_valid == (o_out_word.entry_count != 6'd0), "top valid disagrees with count")
    `KMPQ_ASSERT_NOW(a_more_expired, o_out_valid && !o_out_word.last, o_out_word.status == kmpq_pkg::ST_EXPIRED, "non-final word is not an expiry")

endmodule

bind keyed_max_priority_queue kmpq_chk u_kmpq_chk (.*);

// ===== tb/tb.sv =====
// Testbench for the keyed max priority queue: directed table, random traffic, scoreboard.
module tb;

    localparam int MAX_CYCLES = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    kmpq_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    kmpq_pkg::t_out_word o_out_word;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [kmpq_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    keyed_max_priority_queue dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the queue contents.
    logic        q_valid [kmpq_pkg::DEPTH];
    logic [7:0]  q_key   [kmpq_pkg::DEPTH];
    logic [15:0] q_prio  [kmpq_pkg::DEPTH];
    logic [15:0] q_tag   [kmpq_pkg::DEPTH];
    logic [31:0] q_birth [kmpq_pkg::DEPTH];
    logic [31:0] q_stamp [kmpq_pkg::DEPTH];
    logic [31:0] stamp_ctr;
    int          held;
    logic [15:0] expire_limit;

    kmpq_pkg::t_out_word pending_words[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 9, recv_idle_pct = 80;

    // Directed table entry; chk says whether exp is typed in by hand.
    typedef struct {
        kmpq_pkg::t_in_word  w;
        bit                  chk;
        kmpq_pkg::t_out_word exp;
    } t_row;
    t_row rows[$];

    function automatic int find_key(logic [7:0] k);
        for (int i = 0; i < kmpq_pkg::DEPTH; i++)
            if (q_valid[i] && q_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int find_top();
        int b;
        b = -1;
        for (int i = 0; i < kmpq_pkg::DEPTH; i++) begin
            if (!q_valid[i]) continue;
            if (b < 0 || q_prio[i] > q_prio[b] ||
                (q_prio[i] == q_prio[b] && q_stamp[i] > q_stamp[b])) b = i;
        end
        return b;
    endfunction

    function automatic void queue_word(logic [2:0] st, logic [7:0] k,
                                       logic [15:0] p, logic [15:0] t);
        kmpq_pkg::t_out_word o;
        int tp;
        tp = find_top();
        o.status = st;
        o.result_key = k;
        o.result_priority = p;
        o.result_tag = t;
        o.entry_count = held[5:0];
        o.top_valid = (tp >= 0);
        o.top_key = (tp >= 0) ? q_key[tp] : 8'd0;
        o.last = 1'b0;
        pending_words.push_back(o);
    endfunction

    // Predict the result words of one accepted command.
    function automatic void predict_queue_op(kmpq_pkg::t_in_word w);
        int i, n, b;
        n = 0;
        case (w.operation)
            kmpq_pkg::OP_PUSH: begin
                i = find_key(w.entry_key);
                if (i >= 0) begin
                    if (w.priority_req > q_prio[i]) begin
                        q_prio[i] = w.priority_req;
                        q_tag[i] = w.event_tag;
                        q_stamp[i] = stamp_ctr++;
                        queue_word(kmpq_pkg::ST_RAISED, w.entry_key, 0, 0);
                    end else queue_word(kmpq_pkg::ST_DISCARDED, w.entry_key, 0, 0);
                end else if (held >= kmpq_pkg::DEPTH) begin
                    queue_word(kmpq_pkg::ST_FULL, w.entry_key, 0, 0);
                end else begin
                    for (i = 0; i < kmpq_pkg::DEPTH && q_valid[i]; i++) ;
                    q_valid[i] = 1'b1;
                    q_key[i] = w.entry_key;
                    q_prio[i] = w.priority_req;
                    q_tag[i] = w.event_tag;
                    q_birth[i] = w.now_seconds;
                    q_stamp[i] = stamp_ctr++;
                    held++;
                    queue_word(kmpq_pkg::ST_INSERTED, w.entry_key, 0, 0);
                end
            end
            kmpq_pkg::OP_POP_TOP, kmpq_pkg::OP_POP_KEY: begin
                i = (w.operation == kmpq_pkg::OP_POP_TOP) ? find_top() : find_key(w.entry_key);
                if (i >= 0) begin
                    q_valid[i] = 1'b0;
                    held--;
                    queue_word(kmpq_pkg::ST_REMOVED, q_key[i], q_prio[i], q_tag[i]);
                end else
                    queue_word(kmpq_pkg::ST_NOT_FOUND,
                               (w.operation == kmpq_pkg::OP_POP_KEY) ? w.entry_key : 8'd0,
                               0, 0);
            end
            default: begin
                // Sweep: expired entries leave lowest priority first, oldest stamp on ties.
                if (expire_limit != 0) begin
                    while (n < kmpq_pkg::RESULT_CAP) begin
                        b = -1;
                        for (i = 0; i < kmpq_pkg::DEPTH; i++) begin
                            if (!q_valid[i] ||
                                (w.now_seconds - q_birth[i]) < {16'd0, expire_limit})
                                continue;
                            if (b < 0 || q_prio[i] < q_prio[b] ||
                                (q_prio[i] == q_prio[b] && q_stamp[i] < q_stamp[b])) b = i;
                        end
                        if (b < 0) break;
                        q_valid[b] = 1'b0;
                        held--;
                        queue_word(kmpq_pkg::ST_EXPIRED, q_key[b], q_prio[b], q_tag[b]);
                        n++;
                    end
                end
                if (n == 0) queue_word(kmpq_pkg::ST_NOT_FOUND, 0, 0, 0);
            end
        endcase
        pending_words[$].last = 1'b1;
    endfunction

    // Scoreboard on the result channel.
    always @(posedge i_clk) begin
        kmpq_pkg::t_out_word e;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_out_word);
            end else begin
                e = pending_words.pop_front();
                if (o_out_word !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %h got %h", e, o_out_word);
                end
            end
        end
        if (i_rst_n) i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycles > MAX_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_limit(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= kmpq_pkg::ADDR_W'(kmpq_pkg::REG_EXPIRE_LIMIT) << 2; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        expire_limit = v;
    endtask

    // Drop valid, drain outstanding results, then let the tail of a command settle.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Present one command word and hold it until accepted; valid stays up for
    // a back-to-back word and drops only on an idle cycle or a drain.
    task automatic send_word(kmpq_pkg::t_in_word w, bit chk, kmpq_pkg::t_out_word exp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_queue_op(w);
        if (chk && pending_words[$] !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row mismatch: typed %h predicted %h", exp, pending_words[$]);
        end
    endtask

    function automatic kmpq_pkg::t_in_word mk(logic [1:0] op, logic [7:0] k, logic [15:0] p,
                                              logic [15:0] t, logic [31:0] now);
        kmpq_pkg::t_in_word w;
        w.operation = op; w.entry_key = k; w.priority_req = p;
        w.event_tag = t; w.now_seconds = now;
        return w;
    endfunction

    function automatic kmpq_pkg::t_out_word ex(logic [2:0] st, logic [7:0] k, logic [15:0] p,
                                               logic [15:0] t, logic [5:0] c, logic tv,
                                               logic [7:0] tk);
        kmpq_pkg::t_out_word o;
        o.status = st; o.result_key = k; o.result_priority = p; o.result_tag = t;
        o.entry_count = c; o.top_valid = tv; o.top_key = tk; o.last = 1'b1;
        return o;
    endfunction

    function automatic void add(kmpq_pkg::t_in_word w, bit chk = 0,
                                kmpq_pkg::t_out_word e = '0);
        rows.push_back('{w, chk, e});
    endfunction

    // Random command; mostly pushes on a small key set so hits and raises happen.
    function automatic kmpq_pkg::t_in_word rand_word(logic [31:0] now);
        kmpq_pkg::t_in_word w;
        int r;
        r = $urandom_range(99);
        w = mk(kmpq_pkg::OP_PUSH, 8'($urandom_range(0, 40)), 16'($urandom),
               16'($urandom), now);
        if ($urandom_range(9) == 0) w.entry_key = 8'($urandom);
        if ($urandom_range(7) == 0) w.priority_req = 16'($urandom_range(0, 3));
        if (r >= 55 && r < 72) w.operation = kmpq_pkg::OP_POP_TOP;
        else if (r >= 72 && r < 90) w.operation = kmpq_pkg::OP_POP_KEY;
        else if (r >= 90) w.operation = kmpq_pkg::OP_SWEEP;
        return w;
    endfunction

    initial begin
        logic [31:0] now;
        for (int i = 0; i < kmpq_pkg::DEPTH; i++) q_valid[i] = 1'b0;
        stamp_ctr = 0; held = 0; expire_limit = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pops and sweep, extremes, raise, discard, tie.
        add(mk(kmpq_pkg::OP_POP_TOP, 8'h5A, 0, 0, 0), 1,
            ex(kmpq_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        add(mk(kmpq_pkg::OP_POP_KEY, 8'hFF, 0, 0, 0), 1,
            ex(kmpq_pkg::ST_NOT_FOUND, 8'hFF, 0, 0, 0, 0, 0));
        add(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'hFFFF_FFFF), 1,
            ex(kmpq_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        add(mk(kmpq_pkg::OP_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0), 1,
            ex(kmpq_pkg::ST_INSERTED, 8'hFF, 0, 0, 1, 1, 8'hFF));
        add(mk(kmpq_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h0000, 32'd0));
        add(mk(kmpq_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h1234, 32'd5));
        add(mk(kmpq_pkg::OP_PUSH, 8'h00, 16'h0001, 16'hAAAA, 32'd6));
        add(mk(kmpq_pkg::OP_PUSH, 8'h10, 16'h0001, 16'h5555, 32'd7));
        add(mk(kmpq_pkg::OP_PUSH, 8'h00, 16'h0002, 16'h0F0F, 32'd8));
        add(mk(kmpq_pkg::OP_PUSH, 8'h10, 16'h0002, 16'hF0F0, 32'd9));
        add(mk(kmpq_pkg::OP_POP_TOP, 0, 0, 0, 0));
        add(mk(kmpq_pkg::OP_POP_KEY, 8'h10, 0, 0, 0));
        add(mk(kmpq_pkg::OP_POP_KEY, 8'h10, 0, 0, 0));
        add(mk(kmpq_pkg::OP_POP_TOP, 0, 0, 0, 0));
        add(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'd100));
        foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].exp);

        // Fill to full, drop, then sweep with the smallest and a wrapped age.
        wait_drain();
        write_limit(16'd1);
        for (int k = 0; k < kmpq_pkg::DEPTH + 2; k++)
            send_word(mk(kmpq_pkg::OP_PUSH, 8'(8'h80 + k), 16'($urandom_range(0, 7)),
                         16'($urandom), 32'd10 + 32'(k)),
                      0, '0);
        send_word(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'd20), 0, '0);
        send_word(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'd5), 0, '0);
        wait_drain();
        write_limit(16'hFFFF);
        send_word(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'd0), 0, '0);
        send_word(mk(kmpq_pkg::OP_SWEEP, 0, 0, 0, 32'h0001_0100), 0, '0);

        // Random traffic in three idling phases, limit changed between them.
        now = 32'd1000;
        for (int ph = 0; ph < 3; ph++) begin
            wait_drain();
            case (ph)
                0: begin send_idle_pct = 9;  recv_idle_pct = 80; write_limit(16'd50); end
                1: begin send_idle_pct = 80; recv_idle_pct = 9;  write_limit(16'd0); end
                default: begin send_idle_pct = 0; recv_idle_pct = 0;
                    write_limit(16'($urandom_range(20, 300))); end
            endcase
            for (int n = 0; n < 70; n++) begin
                now += $urandom_range(0, 12);
                if ($urandom_range(29) == 0) now += $urandom;
                send_word(rand_word(now), 0, '0);
                if (n == 35) wait_drain();
            end
        end

        wait_drain();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/kmpq_pkg.sv
rtl/core/kmpq_ram.sv
rtl/core/kmpq_dp.sv
rtl/core/kmpq_ctrl.sv
rtl/core/keyed_max_priority_queue.sv
rtl/core/kmpq_chk.sv
tb/tb.sv
